// ----- hdl/pool_slot_and_bump_allocator_unit_macros.svh -----
// assertion helpers for the pool allocator
`ifndef POOL_SLOT_AND_BUMP_ALLOCATOR_UNIT_MACROS_SVH
`define POOL_SLOT_AND_BUMP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PSBA_CHK_NOW(label, cond, impl, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (impl)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PSBA_CHK_NXT(label, cond, impl, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (impl)) \
        else $error(msg);

`endif

// ----- hdl/psba_pkg.sv -----
package psba_pkg;

    localparam int WORD_COUNT  = 2;
    localparam int WORD_BITS   = 32;
    localparam int POOL_SLOTS  = 64;

    localparam int BITMAP_BITS = WORD_COUNT * WORD_BITS;
    localparam int SLOT_LIMIT  = (POOL_SLOTS < BITMAP_BITS) ? POOL_SLOTS : BITMAP_BITS;
    localparam int BM_W        = $clog2(BITMAP_BITS);
    localparam int ADDR_W      = $clog2(POOL_SLOTS);
    localparam int WC_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int FB_W        = $clog2(WORD_BITS);

    localparam int DATA_W      = 32;
    localparam int IDX_W       = 6;
    localparam int SHIFT_W     = 5;
    localparam int ALU_W       = 34;

    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0]    HUGE_MASK = 32'h001F_FFFF;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_FREE    = 2'd2,
        OP_DESTROY = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ARG   = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_NO_POOL   = 3'd3,
        ST_NO_SPACE  = 3'd4,
        ST_TOO_LARGE = 3'd5,
        ST_BUSY      = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CRT_ADD,
        S_CRT_CHK,
        S_ALC_RND,
        S_ALC_OFF,
        S_ALC_CMP,
        S_ALC_USED,
        S_ALC_WR,
        S_FRE_SUB,
        S_FRE_CHK,
        S_DST_CHK,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   pool_index;
        logic [DATA_W-1:0]  request_size;
        logic [SHIFT_W-1:0] page_shift;
    } t_in_beat;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  slot_index;
        logic [DATA_W-1:0] block_offset;
        logic [DATA_W-1:0] block_length;
        logic [DATA_W-1:0] used_remaining;
    } t_out_beat;

    typedef struct packed {
        logic [DATA_W-1:0] length;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] used;
    } t_pool_entry;

    // request to the shared adder; sub computes a - b, carry out set when a >= b
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

endpackage

// ----- hdl/psba_alu.sv -----
module psba_alu (
    input  logic               i_clk,
    input  psba_pkg::t_alu_req i_req,
    output logic [psba_pkg::ALU_W:0] o_res
);

    logic [psba_pkg::ALU_W:0] r_res;
    logic [psba_pkg::ALU_W:0] n_res;
    logic [psba_pkg::ALU_W-1:0] b_op;

    always_comb begin
        b_op  = i_req.sub ? ~i_req.b : i_req.b;
        n_res = (psba_pkg::ALU_W+1)'(i_req.a) + (psba_pkg::ALU_W+1)'(b_op)
              + (psba_pkg::ALU_W+1)'(i_req.sub);
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- hdl/pool_slot_and_bump_allocator_unit.sv -----
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | i_in  (op, slot, size, page shift)
// out     | output    | o_out_valid / i_out_stall | o_out (status, slot, offset, length, used)
//
// one request at a time; a shared 34-bit adder does the adds and subtract compares in turn
// create: scan bitmap words, add rounding mask, check length; destroy: check used
// alloc: round, add offset, compare, add used, write (no write if it does not fit)
// free: subtract, check; early error: straight to finish; adder and pool reads are registered
// a finished beat waits in the output register; the next request is taken meanwhile
// a stalled output holds the block in its last step until the result register frees
// reset clears the slot bitmap and control state; pool memory is written on create
`include "pool_slot_and_bump_allocator_unit_macros.svh"

module pool_slot_and_bump_allocator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  psba_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output psba_pkg::t_out_beat o_out
);

    psba_pkg::t_state     r_state;
    psba_pkg::t_state     n_state;

    logic [psba_pkg::BITMAP_BITS-1:0] r_bitmap;
    psba_pkg::t_pool_entry            mem [psba_pkg::POOL_SLOTS];
    psba_pkg::t_pool_entry            r_rd;

    psba_pkg::t_in_beat               r_req;
    logic [psba_pkg::BM_W-1:0]        r_bm_slot;
    logic [psba_pkg::WC_W-1:0]        r_word;
    logic [psba_pkg::DATA_W:0]        r_blk;
    logic [psba_pkg::DATA_W-1:0]      r_sum32;
    psba_pkg::t_out_beat              r_res;
    psba_pkg::t_out_beat              n_res;
    psba_pkg::t_out_beat              r_out;
    logic                             r_out_valid;
    logic                             n_out_valid;

    psba_pkg::t_alu_req               alu_req;
    logic [psba_pkg::ALU_W:0]         alu_res;

    logic                             in_fire;
    logic                             out_free;
    logic                             in_range;
    logic                             in_taken;
    psba_pkg::t_status                accept_status;
    psba_pkg::t_out_beat              accept_res;

    logic [psba_pkg::WORD_BITS-1:0]   scan_word;
    logic                             scan_found;
    logic [psba_pkg::FB_W-1:0]        free_bit;
    int                               scan_pos;
    logic                             scan_ok;

    logic [psba_pkg::ALU_W-1:0]       page_mask;
    logic [psba_pkg::DATA_W:0]        blk;
    logic [psba_pkg::DATA_W-1:0]      crt_len;

    logic                             mem_we;
    psba_pkg::t_pool_entry            mem_wdata;
    logic                             bm_set;
    logic                             bm_clr;
    logic                             slot_we;
    logic                             word_inc;
    logic                             save_blk;
    logic                             save_sum;

    psba_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign o_in_stall  = (r_state != psba_pkg::S_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // early checks on the incoming beat
    always_comb begin
        in_range = int'(i_in.pool_index) < psba_pkg::SLOT_LIMIT;
        in_taken = r_bitmap[psba_pkg::BM_W'(i_in.pool_index)];
        if (i_in.op == psba_pkg::OP_CREATE) begin
            accept_status = (i_in.request_size == '0) ? psba_pkg::ST_BAD_ARG : psba_pkg::ST_OK;
        end else if (!in_range) begin
            accept_status = psba_pkg::ST_BAD_ARG;
        end else if (!in_taken) begin
            accept_status = psba_pkg::ST_NO_POOL;
        end else begin
            accept_status = psba_pkg::ST_OK;
        end
        accept_res        = '0;
        accept_res.status = accept_status;
    end

    // lowest clear bit of the current bitmap word
    always_comb begin
        scan_word  = r_bitmap[int'(r_word) * psba_pkg::WORD_BITS +: psba_pkg::WORD_BITS];
        scan_found = (scan_word != psba_pkg::FULL_WORD);
        free_bit   = '0;
        for (int b = psba_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (!scan_word[b]) begin
                free_bit = psba_pkg::FB_W'(b);
            end
        end
        scan_pos = int'(r_word) * psba_pkg::WORD_BITS + int'(free_bit);
        scan_ok  = scan_pos < psba_pkg::SLOT_LIMIT;
    end

    always_comb begin
        page_mask = ~({psba_pkg::ALU_W{1'b1}} << r_req.page_shift);
        blk       = alu_res[psba_pkg::DATA_W:0] & ~page_mask[psba_pkg::DATA_W:0];
        crt_len   = alu_res[psba_pkg::DATA_W-1:0] & ~psba_pkg::HUGE_MASK;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psba_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (accept_status != psba_pkg::ST_OK) begin
                        n_state = psba_pkg::S_FINISH;
                    end else begin
                        unique case (i_in.op)
                            psba_pkg::OP_CREATE:  n_state = psba_pkg::S_SCAN;
                            psba_pkg::OP_ALLOC:   n_state = psba_pkg::S_ALC_RND;
                            psba_pkg::OP_FREE:    n_state = psba_pkg::S_FRE_SUB;
                            psba_pkg::OP_DESTROY: n_state = psba_pkg::S_DST_CHK;
                            default:              n_state = psba_pkg::S_FINISH;
                        endcase
                    end
                end
            end
            psba_pkg::S_SCAN: begin
                if (scan_found) begin
                    n_state = scan_ok ? psba_pkg::S_CRT_ADD : psba_pkg::S_FINISH;
                end else if (r_word == psba_pkg::WC_W'(psba_pkg::WORD_COUNT - 1)) begin
                    n_state = psba_pkg::S_FINISH;
                end
            end
            psba_pkg::S_CRT_ADD:  n_state = psba_pkg::S_CRT_CHK;
            psba_pkg::S_CRT_CHK:  n_state = psba_pkg::S_FINISH;
            psba_pkg::S_ALC_RND:  n_state = psba_pkg::S_ALC_OFF;
            psba_pkg::S_ALC_OFF:  n_state = psba_pkg::S_ALC_CMP;
            psba_pkg::S_ALC_CMP:  n_state = psba_pkg::S_ALC_USED;
            psba_pkg::S_ALC_USED: begin
                n_state = alu_res[psba_pkg::ALU_W] ? psba_pkg::S_ALC_WR : psba_pkg::S_FINISH;
            end
            psba_pkg::S_ALC_WR:   n_state = psba_pkg::S_FINISH;
            psba_pkg::S_FRE_SUB:  n_state = psba_pkg::S_FRE_CHK;
            psba_pkg::S_FRE_CHK:  n_state = psba_pkg::S_FINISH;
            psba_pkg::S_DST_CHK:  n_state = psba_pkg::S_FINISH;
            psba_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = psba_pkg::S_IDLE;
                end
            end
            default: n_state = psba_pkg::S_IDLE;
        endcase
    end

    // step controls
    always_comb begin
        alu_req   = '0;
        mem_we    = 1'b0;
        mem_wdata = r_rd;
        bm_set    = 1'b0;
        bm_clr    = 1'b0;
        slot_we   = 1'b0;
        word_inc  = 1'b0;
        save_blk  = 1'b0;
        save_sum  = 1'b0;
        n_res     = r_res;
        unique case (r_state)
            psba_pkg::S_SCAN: begin
                if (scan_found) begin
                    if (scan_ok) begin
                        slot_we = 1'b1;
                    end else begin
                        n_res.status = psba_pkg::ST_NO_SLOT;
                    end
                end else if (r_word == psba_pkg::WC_W'(psba_pkg::WORD_COUNT - 1)) begin
                    n_res.status = psba_pkg::ST_NO_SLOT;
                end else begin
                    word_inc = 1'b1;
                end
            end
            psba_pkg::S_CRT_ADD: begin
                alu_req.a = psba_pkg::ALU_W'(r_req.request_size);
                alu_req.b = psba_pkg::ALU_W'(psba_pkg::HUGE_MASK);
            end
            psba_pkg::S_CRT_CHK: begin
                // sum past 32 bits means the rounded length does not fit
                if (alu_res[psba_pkg::DATA_W]) begin
                    n_res.status = psba_pkg::ST_TOO_LARGE;
                end else begin
                    mem_we           = 1'b1;
                    mem_wdata.length = crt_len;
                    mem_wdata.offset = '0;
                    mem_wdata.used   = '0;
                    bm_set           = 1'b1;
                    n_res.slot_index   = psba_pkg::IDX_W'(r_bm_slot);
                    n_res.block_length = crt_len;
                end
            end
            psba_pkg::S_ALC_RND: begin
                alu_req.a = psba_pkg::ALU_W'(r_req.request_size);
                alu_req.b = page_mask;
            end
            psba_pkg::S_ALC_OFF: begin
                save_blk  = 1'b1;
                alu_req.a = psba_pkg::ALU_W'(r_rd.offset);
                alu_req.b = psba_pkg::ALU_W'(blk);
            end
            psba_pkg::S_ALC_CMP: begin
                // length - (offset + block), carry out means it fits
                save_sum    = 1'b1;
                alu_req.a   = psba_pkg::ALU_W'(r_rd.length);
                alu_req.b   = alu_res[psba_pkg::ALU_W-1:0];
                alu_req.sub = 1'b1;
            end
            psba_pkg::S_ALC_USED: begin
                if (!alu_res[psba_pkg::ALU_W]) begin
                    n_res.status = psba_pkg::ST_NO_SPACE;
                end else begin
                    alu_req.a = psba_pkg::ALU_W'(r_rd.used);
                    alu_req.b = psba_pkg::ALU_W'(r_blk);
                end
            end
            psba_pkg::S_ALC_WR: begin
                mem_we             = 1'b1;
                mem_wdata.offset   = r_sum32;
                mem_wdata.used     = alu_res[psba_pkg::DATA_W-1:0];
                n_res.block_offset = r_rd.offset;
                n_res.block_length = r_blk[psba_pkg::DATA_W-1:0];
            end
            psba_pkg::S_FRE_SUB: begin
                alu_req.a   = psba_pkg::ALU_W'(r_rd.used);
                alu_req.b   = psba_pkg::ALU_W'(r_req.request_size);
                alu_req.sub = 1'b1;
            end
            psba_pkg::S_FRE_CHK: begin
                if (!alu_res[psba_pkg::ALU_W]) begin
                    n_res.status = psba_pkg::ST_BAD_ARG;
                end else begin
                    mem_we               = 1'b1;
                    mem_wdata.used       = alu_res[psba_pkg::DATA_W-1:0];
                    n_res.used_remaining = alu_res[psba_pkg::DATA_W-1:0];
                end
            end
            psba_pkg::S_DST_CHK: begin
                if (r_rd.used != '0) begin
                    n_res.status = psba_pkg::ST_BUSY;
                end else begin
                    bm_clr = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == psba_pkg::S_FINISH && out_free) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psba_pkg::S_IDLE;
            r_bitmap    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (bm_set) begin
                r_bitmap[r_bm_slot] <= 1'b1;
            end else if (bm_clr) begin
                r_bitmap[r_bm_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req     <= i_in;
            r_bm_slot <= psba_pkg::BM_W'(i_in.pool_index);
            r_word    <= '0;
            r_res     <= accept_res;
        end else begin
            r_res <= n_res;
            if (slot_we) begin
                r_bm_slot <= psba_pkg::BM_W'(scan_pos);
            end
            if (word_inc) begin
                r_word <= r_word + 1'b1;
            end
        end
        if (save_blk) begin
            r_blk <= blk;
        end
        if (save_sum) begin
            r_sum32 <= alu_res[psba_pkg::DATA_W-1:0];
        end
        if (r_state == psba_pkg::S_FINISH && out_free) begin
            r_out <= r_res;
        end
    end

    // pool state memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[psba_pkg::ADDR_W'(r_bm_slot)] <= mem_wdata;
        end
        if (in_fire) begin
            r_rd <= mem[psba_pkg::ADDR_W'(i_in.pool_index)];
        end
    end

    `PSBA_CHK_NXT(a_create_marks_slot, r_state == psba_pkg::S_CRT_CHK && !alu_res[psba_pkg::DATA_W], r_bitmap[r_bm_slot], "created pool slot not marked")
    `PSBA_CHK_NXT(a_destroy_frees_slot, r_state == psba_pkg::S_DST_CHK && r_rd.used == '0, !r_bitmap[r_bm_slot], "destroyed pool slot still marked")
    `PSBA_CHK_NOW(a_alloc_within_pool, r_state == psba_pkg::S_ALC_WR, r_sum32 <= r_rd.length, "allocation runs past pool length")
    `PSBA_CHK_NOW(a_error_fields_zero, r_state == psba_pkg::S_FINISH && r_res.status != psba_pkg::ST_OK, r_res.slot_index == '0 && r_res.block_offset == '0 && r_res.block_length == '0 && r_res.used_remaining == '0, "error result carries nonzero fields")

endmodule

// ----- tb/pool_slot_and_bump_allocator_unit_test.sv -----
module pool_slot_and_bump_allocator_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [63:0] TWO_MIB_MASK = 64'h1F_FFFF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    psba_pkg::t_in_beat  in_beat = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    psba_pkg::t_out_beat out_beat;

    pool_slot_and_bump_allocator_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    // shadow copy of the pool table
    logic [63:0] slot_map;
    logic [31:0] pool_len [64];
    logic [31:0] pool_off [64];
    logic [31:0] pool_use [64];

    psba_pkg::t_out_beat expected_replies [$];
    int fail_count = 0;
    int replies_checked = 0;
    int cycle_count = 0;
    int op_count [4] = '{default: 0};
    int status_count [8] = '{default: 0};
    bit no_idle = 1'b0;
    int reply_hold = 0;

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies pending", cycle_count,
                     expected_replies.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic psba_pkg::t_out_beat predict_pool_request(psba_pkg::t_in_beat req);
        psba_pkg::t_out_beat res;
        logic [63:0] len;
        logic [63:0] page;
        logic [63:0] blk;
        int          s;
        logic [5:0]  idx;
        res = '0;
        res.status = psba_pkg::ST_OK;
        idx = req.pool_index;
        if (req.op == psba_pkg::OP_CREATE) begin
            len = ({32'h0, req.request_size} + TWO_MIB_MASK) & ~TWO_MIB_MASK;
            s = -1;
            for (int i = psba_pkg::SLOT_LIMIT - 1; i >= 0; i--) begin
                if (!slot_map[i]) s = i;
            end
            // zero size wins over a full map, a full map over an oversized length
            if (req.request_size == 32'h0) begin
                res.status = psba_pkg::ST_BAD_ARG;
            end else if (s < 0) begin
                res.status = psba_pkg::ST_NO_SLOT;
            end else if (len > 64'hFFFF_FFFF) begin
                res.status = psba_pkg::ST_TOO_LARGE;
            end else begin
                slot_map[s] = 1'b1;
                pool_len[s] = len[31:0];
                pool_off[s] = 32'h0;
                pool_use[s] = 32'h0;
                res.slot_index = s[5:0];
                res.block_length = len[31:0];
            end
        end else if (int'(idx) >= psba_pkg::SLOT_LIMIT) begin
            res.status = psba_pkg::ST_BAD_ARG;
        end else if (!slot_map[idx]) begin
            res.status = psba_pkg::ST_NO_POOL;
        end else if (req.op == psba_pkg::OP_ALLOC) begin
            page = 64'd1 << req.page_shift;
            blk = ({32'h0, req.request_size} + page - 64'd1) & ~(page - 64'd1);
            if ({32'h0, pool_off[idx]} + blk > {32'h0, pool_len[idx]}) begin
                res.status = psba_pkg::ST_NO_SPACE;
            end else begin
                res.block_offset = pool_off[idx];
                res.block_length = blk[31:0];
                pool_off[idx] = pool_off[idx] + blk[31:0];
                pool_use[idx] = pool_use[idx] + blk[31:0];
            end
        end else if (req.op == psba_pkg::OP_FREE) begin
            if (pool_use[idx] < req.request_size) begin
                res.status = psba_pkg::ST_BAD_ARG;
            end else begin
                pool_use[idx] = pool_use[idx] - req.request_size;
                res.used_remaining = pool_use[idx];
            end
        end else begin
            if (pool_use[idx] != 32'h0) begin
                res.status = psba_pkg::ST_BUSY;
            end else begin
                slot_map[idx] = 1'b0;
            end
        end
        return res;
    endfunction

    // valid stays high across back-to-back beats, lowered only for a gap
    task automatic send_request(psba_pkg::t_op op, int idx, logic [31:0] size, int shift);
        psba_pkg::t_in_beat req;
        int       gap;
        req.op = op;
        req.pool_index = idx[5:0];
        req.request_size = size;
        req.page_shift = shift[4:0];
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= req;
        do @(posedge clk); while (in_stall);
        expected_replies.push_back(predict_pool_request(req));
        op_count[op]++;
    endtask

    always @(posedge clk) begin
        psba_pkg::t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("reply with nothing pending: st=%0d slot=%0d off=%h len=%h used=%h",
                             out_beat.status, out_beat.slot_index, out_beat.block_offset,
                             out_beat.block_length, out_beat.used_remaining);
                end
            end else begin
                want = expected_replies.pop_front();
                if (out_beat.status !== want.status
                        || out_beat.slot_index !== want.slot_index
                        || out_beat.block_offset !== want.block_offset
                        || out_beat.block_length !== want.block_length
                        || out_beat.used_remaining !== want.used_remaining) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("reply %0d: expected st=%0d slot=%0d off=%h len=%h used=%h",
                                 replies_checked, want.status, want.slot_index,
                                 want.block_offset, want.block_length, want.used_remaining);
                        $display("reply %0d: got      st=%0d slot=%0d off=%h len=%h used=%h",
                                 replies_checked, out_beat.status, out_beat.slot_index,
                                 out_beat.block_offset, out_beat.block_length,
                                 out_beat.used_remaining);
                    end
                end
                status_count[want.status]++;
                replies_checked++;
            end
            reply_hold = draw_wait();
        end
        if (reply_hold > 0) begin
            out_stall <= 1'b1;
            reply_hold--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic int live_slot();
        int start;
        start = $urandom_range(0, 63);
        if (slot_map == '0 || $urandom_range(0, 9) == 0) begin
            return start;
        end
        for (int i = 0; i < 64; i++) begin
            if (slot_map[(start + i) % 64]) return (start + i) % 64;
        end
        return start;
    endfunction

    task automatic drain_pools();
        for (int i = 0; i < 64; i++) begin
            if (slot_map[i]) begin
                if (pool_use[i] != 32'h0) send_request(psba_pkg::OP_FREE, i, pool_use[i], 0);
                send_request(psba_pkg::OP_DESTROY, i, 32'h0, 0);
            end
        end
    endtask

    task automatic test_directed_cases();
        no_idle = 1'b0;
        send_request(psba_pkg::OP_CREATE, 0, 32'h0, 0);
        send_request(psba_pkg::OP_ALLOC, 0, 32'h10, 0);
        send_request(psba_pkg::OP_FREE, 63, 32'h0, 0);
        send_request(psba_pkg::OP_DESTROY, 63, 32'h0, 0);
        send_request(psba_pkg::OP_CREATE, 0, 32'h1, 0);
        // length rounding runs past 32 bits
        send_request(psba_pkg::OP_CREATE, 0, 32'hFFFF_FFFF, 0);
        send_request(psba_pkg::OP_CREATE, 0, 32'hFFE0_0001, 0);
        send_request(psba_pkg::OP_CREATE, 63, 32'hFFE0_0000, 31);
        send_request(psba_pkg::OP_ALLOC, 0, 32'h0, 0);
        send_request(psba_pkg::OP_ALLOC, 0, 32'h1, 31);
        // rounds to 4 GiB, fits only if the compare wraps at 32 bits
        send_request(psba_pkg::OP_ALLOC, 1, 32'hFFFF_FFFF, 31);
        send_request(psba_pkg::OP_ALLOC, 1, 32'hFFFF_FFFF, 0);
        send_request(psba_pkg::OP_ALLOC, 0, 32'h1001, 12);
        send_request(psba_pkg::OP_ALLOC, 0, 32'h1F_E000, 13);
        send_request(psba_pkg::OP_ALLOC, 0, 32'h0, 0);
        send_request(psba_pkg::OP_ALLOC, 0, 32'h1, 0);
        send_request(psba_pkg::OP_FREE, 0, 32'h20_0001, 0);
        send_request(psba_pkg::OP_DESTROY, 0, 32'h0, 0);
        send_request(psba_pkg::OP_FREE, 0, 32'h1000, 0);
        send_request(psba_pkg::OP_FREE, 0, 32'h1F_F000, 0);
        // offset stays at the top after the free
        send_request(psba_pkg::OP_ALLOC, 0, 32'h1, 0);
        send_request(psba_pkg::OP_DESTROY, 0, 32'h0, 0);
        send_request(psba_pkg::OP_ALLOC, 1, 32'hFFE0_0000, 0);
        send_request(psba_pkg::OP_FREE, 1, 32'hFFE0_0000, 0);
        send_request(psba_pkg::OP_DESTROY, 1, 32'hFFFF_FFFF, 31);
    endtask

    task automatic test_slot_exhaustion();
        no_idle = 1'b1;
        while (slot_map != '1) begin
            send_request(psba_pkg::OP_CREATE, $urandom_range(0, 63),
                         $urandom_range(1, 32'h40_0000), $urandom_range(0, 31));
        end
        no_idle = 1'b0;
        send_request(psba_pkg::OP_CREATE, 0, 32'h1, 0);
        send_request(psba_pkg::OP_CREATE, 0, 32'hFFFF_FFFF, 0);
        send_request(psba_pkg::OP_CREATE, 0, 32'h0, 0);
        repeat (6) send_request(psba_pkg::OP_DESTROY, $urandom_range(0, 63), 32'h0, 0);
        repeat (4) send_request(psba_pkg::OP_CREATE, 0, $urandom_range(1, 32'h40_0000), 0);
        drain_pools();
    endtask

    task automatic test_random_traffic(int count);
        int          pick;
        int          idx;
        int          shift;
        logic [31:0] size;
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            shift = $urandom_range(0, 31);
            if (pick < 15) begin
                case ($urandom_range(0, 9))
                    0: size = 32'h0;
                    1: size = $urandom;
                    default: size = $urandom_range(1, 32'h80_0000);
                endcase
                send_request(psba_pkg::OP_CREATE, $urandom_range(0, 63), size, shift);
            end else if (pick < 60) begin
                idx = live_slot();
                if ($urandom_range(0, 3) != 0) shift = $urandom_range(0, 16);
                case ($urandom_range(0, 9))
                    0: size = $urandom;
                    1: size = 32'h0;
                    default: size = $urandom_range(0, 32'h4_0000);
                endcase
                send_request(psba_pkg::OP_ALLOC, idx, size, shift);
            end else if (pick < 88) begin
                idx = live_slot();
                case ($urandom_range(0, 9))
                    0: size = $urandom;
                    1: size = pool_use[idx];
                    2: size = pool_use[idx] + 32'd1;
                    default: size = $urandom_range(0, pool_use[idx]);
                endcase
                send_request(psba_pkg::OP_FREE, idx, size, shift);
            end else begin
                idx = live_slot();
                if (slot_map[idx] && pool_use[idx] != 32'h0 && $urandom_range(0, 1) == 1) begin
                    send_request(psba_pkg::OP_FREE, idx, pool_use[idx], shift);
                end
                send_request(psba_pkg::OP_DESTROY, idx, $urandom, shift);
            end
        end
    endtask

    initial begin
        slot_map = '0;
        for (int i = 0; i < 64; i++) begin
            pool_len[i] = 32'h0;
            pool_off[i] = 32'h0;
            pool_use[i] = 32'h0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_slot_exhaustion();
        test_random_traffic(1350);
        in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        $display("requests: %0d create, %0d alloc, %0d free, %0d destroy; %0d replies checked",
                 op_count[psba_pkg::OP_CREATE], op_count[psba_pkg::OP_ALLOC],
                 op_count[psba_pkg::OP_FREE], op_count[psba_pkg::OP_DESTROY], replies_checked);
        $display("outcomes: ok %0d, bad arg %0d, no slot %0d, no pool %0d, no space %0d, %s %0d, %s %0d",
                 status_count[psba_pkg::ST_OK], status_count[psba_pkg::ST_BAD_ARG],
                 status_count[psba_pkg::ST_NO_SLOT], status_count[psba_pkg::ST_NO_POOL],
                 status_count[psba_pkg::ST_NO_SPACE], "too large",
                 status_count[psba_pkg::ST_TOO_LARGE], "busy", status_count[psba_pkg::ST_BUSY]);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
